@@ src/nth_weekday_of_month_macros.svh @@
// ============================================================================
// nth_weekday_of_month assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef NTH_WEEKDAY_OF_MONTH_MACROS_SVH
`define NTH_WEEKDAY_OF_MONTH_MACROS_SVH

// same-cycle implication
`define NWOM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NWOM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/nwom_pkg.sv @@
// ============================================================================
// nwom_pkg
// Types, constants and calendar helpers for the nth weekday of month block.
// ============================================================================
package nwom_pkg;

    localparam int EPOCH_YEAR   = 1850;
    localparam int DAYS_LEAP    = 366;
    localparam int DAYS_COMMON  = 365;
    localparam int CENTURY      = 100;
    localparam int QUAD_CENTURY = 400;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int WEEK_W  = 3;
    localparam int WDAY_W  = 3;
    localparam int DAY_W   = 5;
    localparam int CFG_W   = 4;

    // days from 0000-01-01 to the epoch, mod 7
    localparam int EPOCH_MOD = (DAYS_COMMON * EPOCH_YEAR + (EPOCH_YEAR + 3) / 4
                               - (EPOCH_YEAR + CENTURY - 1) / CENTURY
                               + (EPOCH_YEAR + QUAD_CENTURY - 1) / QUAD_CENTURY) % 7;
    // epoch is a Tuesday (1 in Monday-zero count); fold that into the start value
    localparam logic [2:0] DOW_INIT    = 3'((7 - EPOCH_MOD + 1) % 7);
    localparam logic [2:0] STEP_LEAP   = 3'(DAYS_LEAP % 7);
    localparam logic [2:0] STEP_COMMON = 3'(DAYS_COMMON % 7);

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_TARGET_MONTH   = 2'd0;
    localparam cfg_idx_t CFG_WEEK_NUMBER    = 2'd1;
    localparam cfg_idx_t CFG_TARGET_WEEKDAY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_YEARS,
        ST_MONTHS,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic year_step;
        logic month_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cfg_ok;
        logic year_done;
        logic month_done;
    } dp_status_t;

    // length of month m; 0 for a month code outside 1..12
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic lp);
        logic [DAY_W-1:0] d;
        d = '0;
        if (m != 4'd0 && m <= MONTH_DEC)
        begin
            d = MONTH_LEN[m - 4'd1];
        end
        if (m == MONTH_FEB && !lp)
        begin
            d = 5'd28;
        end
        return d;
    endfunction

    // month length mod 7: lengths are 28..31
    function automatic logic [2:0] month_mod7(input logic [MONTH_W-1:0] m,
                                              input logic lp);
        logic [DAY_W-1:0] d;
        d = month_days(m, lp);
        return (d >= 5'd28) ? 3'(d - 5'd28) : 3'd0;
    endfunction

endpackage

@@ src/nwom_ctrl.sv @@
// ============================================================================
// nwom_ctrl
// Sequencer: accept a year, walk the years, walk the months, hand off result.
// ============================================================================
module nwom_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  nwom_pkg::dp_status_t status,
    output nwom_pkg::ctrl_cmd_t  cmd
);
    import nwom_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = status.cfg_ok ? ST_YEARS : ST_FINISH;
                end
            end
            ST_YEARS:
            begin
                if (status.year_done)
                begin
                    state_next = ST_MONTHS;
                end
            end
            ST_MONTHS:
            begin
                if (status.month_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            ST_YEARS:
            begin
                cmd.year_step = !status.year_done;
            end
            ST_MONTHS:
            begin
                cmd.month_step = !status.month_done;
            end
            ST_FINISH:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ src/nwom_dp.sv @@
// ============================================================================
// nwom_dp
// Config registers, year/month weekday accumulator and result register.
// ============================================================================
module nwom_dp
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  nwom_pkg::cfg_idx_t                     cfg_index,
    input  logic [nwom_pkg::CFG_W-1:0]             cfg_data,
    input  logic [nwom_pkg::YEAR_W-1:0]            year_in,
    input  nwom_pkg::ctrl_cmd_t                    cmd,
    output nwom_pkg::dp_status_t                   status,
    output logic [nwom_pkg::YEAR_W-1:0]            year_out,
    output logic                                   found,
    output logic [nwom_pkg::DAY_W-1:0]             day_of_month
);
    import nwom_pkg::*;

    logic [MONTH_W-1:0] target_month_reg;
    logic [WEEK_W-1:0]  week_number_reg;
    logic [WDAY_W-1:0]  target_weekday_reg;

    logic [YEAR_W-1:0]  year_reg;
    logic [YEAR_W-1:0]  cnt_reg;
    logic [1:0]         c4_reg;
    logic [6:0]         c100_reg;
    logic [8:0]         c400_reg;
    logic [2:0]         dow_reg;
    logic [MONTH_W-1:0] mon_reg;
    logic [2:0]         dow_next;

    logic [YEAR_W-1:0]  out_year_reg;
    logic               out_found_reg;
    logic [DAY_W-1:0]   out_day_reg;

    logic               leap;
    logic [3:0]         dow_sum;
    logic [3:0]         fsum;
    logic [2:0]         first;
    logic [WEEK_W-1:0]  wm1;
    logic [5:0]         cand;
    logic [DAY_W-1:0]   mdays;
    logic               hit;

    // configuration, reset to month 1, first occurrence, Monday
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_month_reg   <= 4'd1;
            week_number_reg    <= 3'd1;
            target_weekday_reg <= 3'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET_MONTH:   target_month_reg   <= cfg_data;
                CFG_WEEK_NUMBER:    week_number_reg    <= cfg_data[WEEK_W-1:0];
                CFG_TARGET_WEEKDAY: target_weekday_reg <= cfg_data[WDAY_W-1:0];
                default:            ;
            endcase
        end
    end

    // leap rule applied to the year held in cnt_reg
    assign leap = (c400_reg == 9'd0) || (c4_reg == 2'd0 && c100_reg != 7'd0);

    always_comb
    begin
        dow_sum = '0;
        if (cmd.month_step)
        begin
            dow_sum = {1'b0, dow_reg} + {1'b0, month_mod7(mon_reg, leap)};
        end
        else
        begin
            dow_sum = {1'b0, dow_reg} + {1'b0, (leap ? STEP_LEAP : STEP_COMMON)};
        end
        dow_next = (dow_sum >= 4'd7) ? 3'(dow_sum - 4'd7) : dow_sum[2:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            year_reg <= year_in;
            cnt_reg  <= '0;
            c4_reg   <= '0;
            c100_reg <= '0;
            c400_reg <= '0;
            dow_reg  <= DOW_INIT;
            mon_reg  <= 4'd1;
        end
        else if (cmd.year_step)
        begin
            cnt_reg  <= cnt_reg + 12'd1;
            c4_reg   <= c4_reg + 2'd1;
            c100_reg <= (c100_reg == 7'(CENTURY - 1)) ? 7'd0 : c100_reg + 7'd1;
            c400_reg <= (c400_reg == 9'(QUAD_CENTURY - 1)) ? 9'd0 : c400_reg + 9'd1;
            dow_reg  <= dow_next;
        end
        else if (cmd.month_step)
        begin
            mon_reg <= mon_reg + 4'd1;
            dow_reg <= dow_next;
        end
    end

    assign status.cfg_ok     = (target_month_reg != 4'd0) && (target_month_reg <= MONTH_DEC)
                               && (week_number_reg != 3'd0) && (target_weekday_reg != 3'd0);
    assign status.year_done  = (cnt_reg == year_reg);
    assign status.month_done = (mon_reg == target_month_reg);

    // offset of the first wanted weekday from the 1st, then the nth occurrence
    always_comb
    begin
        fsum  = {1'b0, target_weekday_reg} + 4'd6 - {1'b0, dow_reg};
        first = (fsum >= 4'd7) ? 3'(fsum - 4'd7) : fsum[2:0];
        wm1   = week_number_reg - 3'd1;
        cand  = 6'd1 + {3'b0, first} + ({3'b0, wm1} * 6'd7);
        mdays = month_days(target_month_reg, leap);
        hit   = status.cfg_ok && (cand <= {1'b0, mdays});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_year_reg  <= year_reg;
            out_found_reg <= hit;
            out_day_reg   <= hit ? cand[DAY_W-1:0] : '0;
        end
    end

    assign year_out     = out_year_reg;
    assign found        = out_found_reg;
    assign day_of_month = out_day_reg;

endmodule

@@ src/nth_weekday_of_month.sv @@
// The year walk steps the datapath accumulator one calendar year per cycle, then the month
//   walk steps it to the target month; both walks are skipped when month is 0 or above 12,
//   or week or weekday is 0. A new year is taken only in idle, once the last result has
//   been loaded into the output register.
// The result sits in an output register, so a new year is taken while it waits.
// Reset (rst_n low, async): no item in flight, m_tvalid low, all three settings 1.
// ============================================================================
// nth_weekday_of_month
// Day of month of the nth given weekday in the configured month of a year.
// ============================================================================
module nth_weekday_of_month
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] year, [15:12] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [11:0] year_out, [16:12] day_of_month, [23:17] zero
    output logic        m_tuser,   // [0] found
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index, // 0 target_month, 1 week_number, 2 target_weekday
    input  logic [3:0]  cfg_data
);
    import nwom_pkg::*;

    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic [YEAR_W-1:0] year_out;
    logic              found;
    logic [DAY_W-1:0]  day_of_month;

    // config registers accept a write every cycle
    assign cfg_ready = 1'b1;

    nwom_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nwom_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .year_in      (s_tdata[YEAR_W-1:0]),
        .cmd          (cmd),
        .status       (status),
        .year_out     (year_out),
        .found        (found),
        .day_of_month (day_of_month)
    );

    assign m_tdata = {7'd0, day_of_month, year_out};
    assign m_tuser = found;

endmodule

@@ src/nwom_checker.sv @@
// ============================================================================
// nwom_checker
// Port-level checks for nth_weekday_of_month, bound to the top level.
// ============================================================================
`include "nth_weekday_of_month_macros.svh"

module nwom_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // a held result is not withdrawn
    `NWOM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // one item at a time: input closes right after a transfer
    `NWOM_ASSERT_NEXT(a_in_busy, s_tvalid && s_tready, !s_tready, "input open while busy")

    // not found means day zero
    `NWOM_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser, m_tdata[16:12] == 5'd0, "day set on miss")

    // found means a real day
    `NWOM_ASSERT_NOW(a_hit_day, m_tvalid && m_tuser, m_tdata[16:12] != 5'd0, "zero day on hit")

endmodule

bind nth_weekday_of_month nwom_checker u_nwom_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
